### hw/rtl/pfse_pkg.sv
// Package with the item types, command codes, constants and square helpers of the encryptor.
package pfse_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS = SQUARE_SIDE * SQUARE_SIDE;
    localparam int ALPHABET = 26;
    localparam int LETTER_W = 5;
    localparam int POS_W = $clog2(CELLS);
    localparam int ROW_W = $clog2(SQUARE_SIDE);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LETTER_W-1:0] LET_I = LETTER_W'(8);
    localparam logic [LETTER_W-1:0] LET_J = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] LET_Q = LETTER_W'(16);
    localparam logic [LETTER_W-1:0] LET_X = LETTER_W'(23);
    localparam logic [LETTER_W-1:0] LET_LAST = LETTER_W'(ALPHABET - 1);

    localparam logic [7:0] CODE_UPPER_A = 8'h41;
    localparam logic [7:0] CODE_UPPER_Z = 8'h5A;
    localparam logic [7:0] CODE_LOWER_A = 8'h61;
    localparam logic [7:0] CODE_LOWER_Z = 8'h7A;

    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_KEY    = 3'd1,
        MODE_FINISH = 3'd2,
        MODE_TEXT   = 3'd3,
        MODE_END    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_KEY,
        OP_FINISH,
        OP_TEXT,
        OP_END
    } op_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] char_code;
    } char_item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] first_letter;
        logic [LETTER_W-1:0] second_letter;
        logic                last_pair;
    } pair_item_t;

    typedef struct packed {
        op_t                 op;
        logic [LETTER_W-1:0] letter;
    } cmd_t;

    function automatic logic [ROW_W-1:0] pos_row(input logic [POS_W-1:0] pos);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int k = 1; k < SQUARE_SIDE; k++)
        begin
            if (pos >= POS_W'(k * SQUARE_SIDE))
            begin
                r = ROW_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] pos_col(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] base;
        base = POS_W'(pos_row(pos) * SQUARE_SIDE);
        return ROW_W'(pos - base);
    endfunction

    function automatic logic [ROW_W-1:0] wrap_next(input logic [ROW_W-1:0] v);
        return (v == ROW_W'(SQUARE_SIDE - 1)) ? '0 : ROW_W'(v + 1'b1);
    endfunction

    function automatic logic [POS_W-1:0] cell_at(input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] c);
        return POS_W'(r * SQUARE_SIDE + c);
    endfunction

    function automatic logic [LETTER_W-1:0] filler_for(input logic [LETTER_W-1:0] first);
        return (first == LET_X) ? LET_Q : LET_X;
    endfunction

endpackage

### hw/rtl/pfse_fifo.sv
// Small first-in first-out queue used between the front, the back and the result port.
module pfse_fifo #(
    parameter int  DEPTH = pfse_pkg::QUEUE_DEPTH,
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t wdata,
    input  logic  pop,
    output logic  empty,
    output item_t rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

endmodule

### hw/rtl/pfse_front.sv
// Front end: decodes each input item into a command and drops items that have no effect.
module pfse_front (
    input  logic                 push,
    output logic                 full,
    input  pfse_pkg::char_item_t char_item,
    output logic                 cmd_push,
    input  logic                 cmd_full,
    output pfse_pkg::cmd_t       cmd
);

    logic                          is_upper;
    logic                          is_lower;
    logic                          is_letter;
    logic [7:0]                    offset;
    logic [pfse_pkg::LETTER_W-1:0] letter;
    logic                          keep;

    always_comb
    begin
        is_upper  = (char_item.char_code >= pfse_pkg::CODE_UPPER_A)
                 && (char_item.char_code <= pfse_pkg::CODE_UPPER_Z);
        is_lower  = (char_item.char_code >= pfse_pkg::CODE_LOWER_A)
                 && (char_item.char_code <= pfse_pkg::CODE_LOWER_Z);
        is_letter = is_upper || is_lower;
        offset    = is_upper ? pfse_pkg::CODE_UPPER_A : pfse_pkg::CODE_LOWER_A;
        letter    = pfse_pkg::LETTER_W'(char_item.char_code - offset);
        if (letter == pfse_pkg::LET_J)
        begin
            letter = pfse_pkg::LET_I;
        end

        keep       = 1'b0;
        cmd.op     = pfse_pkg::OP_CLEAR;
        cmd.letter = letter;
        case (char_item.mode)
            pfse_pkg::MODE_CLEAR:
            begin
                keep   = 1'b1;
                cmd.op = pfse_pkg::OP_CLEAR;
            end
            pfse_pkg::MODE_KEY:
            begin
                keep   = is_letter;
                cmd.op = pfse_pkg::OP_KEY;
            end
            pfse_pkg::MODE_FINISH:
            begin
                keep   = 1'b1;
                cmd.op = pfse_pkg::OP_FINISH;
            end
            pfse_pkg::MODE_TEXT:
            begin
                keep   = is_letter;
                cmd.op = pfse_pkg::OP_TEXT;
            end
            pfse_pkg::MODE_END:
            begin
                keep   = 1'b1;
                cmd.op = pfse_pkg::OP_END;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full && keep;

endmodule

### hw/rtl/pfse_back.sv
// Back end: builds the key square, pairs text letters and enciphers each pair.
module pfse_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfse_pkg::cmd_t       cmd,
    input  logic                 cmd_empty,
    output logic                 cmd_pop,
    output logic                 res_push,
    input  logic                 res_full,
    output pfse_pkg::pair_item_t res
);

    localparam int LW = pfse_pkg::LETTER_W;
    localparam int PW = pfse_pkg::POS_W;
    localparam int RW = pfse_pkg::ROW_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_RDPOS,
        ST_RDKEY,
        ST_EMIT
    } state_t;

    state_t                         state_reg, state_next;
    logic [PW-1:0]                  fill_reg, fill_next;
    logic [pfse_pkg::ALPHABET-1:0]  used_reg, used_next;
    logic [LW-1:0]                  pend_reg, pend_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [LW-1:0]                  walk_reg, walk_next;
    logic [LW-1:0]                  a_reg, a_next;
    logic [LW-1:0]                  b_reg, b_next;
    logic                           last_reg, last_next;

    logic [LW-1:0] key_mem [pfse_pkg::CELLS];
    logic [PW-1:0] pos_mem [pfse_pkg::ALPHABET];
    logic [PW-1:0] pa_reg, pb_reg;
    logic [LW-1:0] ka_reg, kb_reg;

    logic [LW-1:0] place_letter;
    logic          place_try;
    logic          place_we;

    logic [RW-1:0] r1, c1, r2, c2;
    logic [PW-1:0] o1, o2;

    assign cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty;
    assign res_push = (state_reg == ST_EMIT) && !res_full;
    assign res.first_letter  = ka_reg;
    assign res.second_letter = kb_reg;
    assign res.last_pair     = last_reg;

    always_comb
    begin
        if (state_reg == ST_WALK)
        begin
            place_letter = walk_reg;
            place_try    = (walk_reg != pfse_pkg::LET_J);
        end
        else
        begin
            place_letter = cmd.letter;
            place_try    = cmd_pop && (cmd.op == pfse_pkg::OP_KEY);
        end
        place_we = place_try && !used_reg[place_letter]
                && (fill_reg < PW'(pfse_pkg::CELLS));
    end

    always_comb
    begin
        r1 = pfse_pkg::pos_row(pa_reg);
        c1 = pfse_pkg::pos_col(pa_reg);
        r2 = pfse_pkg::pos_row(pb_reg);
        c2 = pfse_pkg::pos_col(pb_reg);
        if (r1 == r2)
        begin
            o1 = pfse_pkg::cell_at(r1, pfse_pkg::wrap_next(c1));
            o2 = pfse_pkg::cell_at(r2, pfse_pkg::wrap_next(c2));
        end
        else if (c1 == c2)
        begin
            o1 = pfse_pkg::cell_at(pfse_pkg::wrap_next(r1), c1);
            o2 = pfse_pkg::cell_at(pfse_pkg::wrap_next(r2), c2);
        end
        else
        begin
            o1 = pfse_pkg::cell_at(r1, c2);
            o2 = pfse_pkg::cell_at(r2, c1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (place_we)
        begin
            key_mem[fill_reg]     <= place_letter;
            pos_mem[place_letter] <= fill_reg;
        end
        if (state_reg == ST_RDPOS)
        begin
            pa_reg <= pos_mem[a_reg];
            pb_reg <= pos_mem[b_reg];
        end
        if (state_reg == ST_RDKEY)
        begin
            ka_reg <= key_mem[o1];
            kb_reg <= key_mem[o2];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        used_next       = used_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        walk_next       = walk_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        last_next       = last_reg;

        if (place_we)
        begin
            used_next[place_letter] = 1'b1;
            fill_next               = PW'(fill_reg + 1'b1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop)
                begin
                    case (cmd.op)
                        pfse_pkg::OP_CLEAR:
                        begin
                            used_next = '0;
                            fill_next = '0;
                        end
                        pfse_pkg::OP_FINISH:
                        begin
                            walk_next  = '0;
                            state_next = ST_WALK;
                        end
                        pfse_pkg::OP_TEXT:
                        begin
                            if (!pend_valid_reg)
                            begin
                                pend_next       = cmd.letter;
                                pend_valid_next = 1'b1;
                            end
                            else
                            begin
                                a_next     = pend_reg;
                                last_next  = 1'b0;
                                state_next = ST_RDPOS;
                                if (cmd.letter == pend_reg)
                                begin
                                    b_next = pfse_pkg::filler_for(pend_reg);
                                end
                                else
                                begin
                                    b_next          = cmd.letter;
                                    pend_valid_next = 1'b0;
                                end
                            end
                        end
                        pfse_pkg::OP_END:
                        begin
                            if (pend_valid_reg)
                            begin
                                a_next          = pend_reg;
                                b_next          = pfse_pkg::filler_for(pend_reg);
                                last_next       = 1'b1;
                                pend_valid_next = 1'b0;
                                state_next      = ST_RDPOS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (walk_reg == pfse_pkg::LET_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    walk_next = LW'(walk_reg + 1'b1);
                end
            end
            ST_RDPOS:
            begin
                state_next = ST_RDKEY;
            end
            ST_RDKEY:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            used_reg       <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            walk_reg       <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            used_reg       <= used_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            walk_reg       <= walk_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            last_reg       <= last_next;
        end
    end

endmodule

### hw/rtl/playfair_stream_encryptor_top.sv
// Top level of the Playfair stream encryptor: front end, command queue, back end, result queue.
//
//   Channel   Direction  Handshake           Payload
//   char      in         push / full         char_item (mode, char_code)
//   pair      out        empty / pop         pair_item (first_letter, second_letter, last_pair)
//
// A text letter that completes a pair passes through the back-end steps command pop, position
// table read, key square read and result write, as does an end item with a pending letter.
// Other items need only the command pop, except finishing the key square: pop, then a walk over every letter.
// The command queue lets items be accepted while the back end works; full rises when it fills.
// Reset clears the queues, the used-letter flags, the fill count and the pending letter.
// A full result queue holds the back end in its result write until pop frees a slot.
module playfair_stream_encryptor_top #(
    parameter int QUEUE_DEPTH = pfse_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pfse_pkg::char_item_t char_item,
    output logic                 empty,
    input  logic                 pop,
    output pfse_pkg::pair_item_t pair_item
);

    logic                 cmd_push;
    logic                 cmd_full;
    logic                 cmd_pop;
    logic                 cmd_empty;
    pfse_pkg::cmd_t       cmd_in;
    pfse_pkg::cmd_t       cmd_out;
    logic                 res_push;
    logic                 res_full;
    pfse_pkg::pair_item_t res;

    pfse_front u_front (
        .push      (push),
        .full      (full),
        .char_item (char_item),
        .cmd_push  (cmd_push),
        .cmd_full  (cmd_full),
        .cmd       (cmd_in)
    );

    pfse_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .item_t (pfse_pkg::cmd_t)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .full  (cmd_full),
        .wdata (cmd_in),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (cmd_out)
    );

    pfse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res_full  (res_full),
        .res       (res)
    );

    pfse_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .item_t (pfse_pkg::pair_item_t)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res),
        .pop   (pop),
        .empty (empty),
        .rdata (pair_item)
    );

endmodule

### hw/rtl/pfse_checker.sv
// Port-level checker for the Playfair stream encryptor and its bind to the top level.
module pfse_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input pfse_pkg::pair_item_t pair_item
);

    // While reset is held, both queues show as drained.
    a_reset_clear: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queues not drained during reset");

    // The command queue only fills through an accepted item.
    a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an accepted item");

    // A result cannot appear until reset has stayed released through the pop and reads that produce it.
    a_result_latency: assert property (@(posedge clk)
        !empty |-> ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)))
        else $error("result appeared too soon after reset");

    // A waiting result that is not taken stays on the ports unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pair_item)))
        else $error("waiting result changed or vanished");

endmodule

bind playfair_stream_encryptor_top pfse_checker u_pfse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .pair_item (pair_item)
);
